@@ design/mcfg_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor command frame generator package
// Shared widths, codes, frame constants and the frame assembly function.
// ----------------------------------------------------------------------------
package mcfg_pkg;

	// Field widths of the command and frame channels.
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 15;
	localparam int ID_W     = 11;
	localparam int SPEED_W  = 12;
	localparam int TORQUE_W = 15;
	localparam int SEL2_W   = 2;
	localparam int HB_W     = 4;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PERIOD_W   = 16;

	// Job queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Reset values of the configuration registers.
	localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 16'd250;
	localparam logic [PERIOD_W-1:0] RAMP_GAP_RST     = 16'd2;
	localparam logic [SPEED_W-1:0]  SPEED_LIMIT_RST  = 12'd2500;

	// Frame identifiers and data constants.
	localparam logic [ID_W-1:0] ID_SPEED  = 11'h232;
	localparam logic [ID_W-1:0] ID_TORQUE = 11'h233;
	localparam logic [ID_W-1:0] ID_POWER  = 11'h234;
	localparam logic [15:0] SPEED_OFFSET     = 16'd20000;
	localparam logic [15:0] TORQUE_OFFSET    = 16'h7530;
	localparam logic [7:0]  SPEED_FLAG_BYTE  = 8'h01;
	localparam logic [7:0]  POWER_LIMIT_BYTE = 8'h27;
	localparam logic [7:0]  POWER_MODE_BYTE  = 8'h60;
	localparam logic [7:0]  CHECKSUM_BIAS    = 8'd3;
	localparam logic [HB_W-1:0] HB_STEP      = 4'd2;

	// Command operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_TICK      = 3'd0,
		OP_SET_STATE = 3'd1,
		OP_SET_GEAR  = 3'd2,
		OP_SET_SPEED = 3'd3,
		OP_SET_TORQ  = 3'd4,
		OP_STOP      = 3'd5
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_PERIOD = 2'd0,
		CFG_RAMP_GAP     = 2'd1,
		CFG_SPEED_LIMIT  = 2'd2
	} cfg_reg_t;

	// Which frame of a run the back part is producing.
	typedef enum logic [1:0] {
		FRM_SPEED  = 2'd0,
		FRM_TORQUE = 2'd1,
		FRM_POWER  = 2'd2
	} frame_sel_t;

	// Snapshot of the drive state taken when a tick fires a frame run.
	typedef struct packed {
		logic [SPEED_W-1:0]  speed;
		logic [TORQUE_W-1:0] torque;
		logic [SEL2_W-1:0]   drive_state;
		logic [SEL2_W-1:0]   gear;
		logic [HB_W-1:0]     heartbeat;
	} mcfg_job_t;

	// One assembled frame; byte 7 is the checksum.
	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [7:0][7:0]     bytes;
		logic                last;
	} mcfg_frame_t;

	// Build one frame of a run from a job snapshot, checksum included.
	function automatic mcfg_frame_t build_frame(input mcfg_job_t job, input frame_sel_t sel);
		mcfg_frame_t f;
		logic [15:0] sp;
		logic [15:0] up;
		logic [15:0] lo;
		logic [7:0]  sum;
		sp = SPEED_OFFSET + 16'(job.speed);
		up = TORQUE_OFFSET + 16'(job.torque);
		lo = TORQUE_OFFSET - 16'(job.torque);
		f.id = '0;
		f.bytes = '0;
		f.last = 1'b0;
		unique case (sel)
			FRM_SPEED: begin
				f.id = ID_SPEED;
				f.bytes[0] = sp[15:8];
				f.bytes[1] = sp[7:0];
				f.bytes[5] = SPEED_FLAG_BYTE;
				f.bytes[6] = {job.drive_state, job.gear, job.heartbeat};
			end
			FRM_TORQUE: begin
				f.id = ID_TORQUE;
				f.bytes[0] = up[15:8];
				f.bytes[1] = up[7:0];
				f.bytes[2] = lo[15:8];
				f.bytes[3] = lo[7:0];
				f.bytes[4] = TORQUE_OFFSET[15:8];
				f.bytes[5] = TORQUE_OFFSET[7:0];
				f.bytes[6] = 8'(job.heartbeat);
			end
			FRM_POWER: begin
				f.id = ID_POWER;
				f.bytes[0] = POWER_LIMIT_BYTE;
				f.bytes[2] = POWER_LIMIT_BYTE;
				f.bytes[5] = POWER_MODE_BYTE;
				f.bytes[6] = 8'(job.heartbeat);
				f.last = 1'b1;
			end
			default: begin
				f.id = '0;
			end
		endcase
		// Checksum: two's complement of the identifier low byte, data and bias.
		sum = f.id[7:0] + CHECKSUM_BIAS;
		for (int k = 0; k < 7; k++) begin
			sum = sum + f.bytes[k];
		end
		f.bytes[7] = 8'h00 - sum;
		return f;
	endfunction

endpackage

@@ design/mcfg_ifs.sv @@
// ----------------------------------------------------------------------------
// Motor command frame generator channel interfaces
// Command channel and frame channel, each with valid/ready and payload.
// ----------------------------------------------------------------------------
interface mcfg_cmd_if;
	import mcfg_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface mcfg_frame_if;
	import mcfg_pkg::*;

	logic            valid;
	logic            ready;
	logic [ID_W-1:0] frame_id;
	logic [7:0]      byte_zero;
	logic [7:0]      byte_one;
	logic [7:0]      byte_two;
	logic [7:0]      byte_three;
	logic [7:0]      byte_four;
	logic [7:0]      byte_five;
	logic [7:0]      byte_six;
	logic [7:0]      byte_seven;
	logic            last_frame;

	modport source (output valid, output frame_id, output byte_zero, output byte_one,
		output byte_two, output byte_three, output byte_four, output byte_five,
		output byte_six, output byte_seven, output last_frame, input ready);
	modport sink (input valid, input frame_id, input byte_zero, input byte_one,
		input byte_two, input byte_three, input byte_four, input byte_five,
		input byte_six, input byte_seven, input last_frame, output ready);
endinterface

@@ design/motor_command_frame_generator_top.sv @@
// ----------------------------------------------------------------------------
// Motor command frame generator
// Keeps drive state from operator commands and emits motor command frames.
// ----------------------------------------------------------------------------
// Usage:
// The cmd channel takes one command per transaction: a millisecond tick or a
// set operation (drive state, gear, speed request, torque, stop). The frame
// channel delivers 8-byte command frames; a firing tick yields three of them
// (0x232, 0x233, 0x234), the third marked with last_frame. Configuration
// registers are written through cfg_we, cfg_index and cfg_data while idle.
// Throughput is one command per cycle while the job queue is not full. A
// firing tick puts a job in a two-entry queue; the back part turns it into
// three frames at one frame per cycle while the receiver takes them.
// The first frame of a run passes through the queue and then the output
// register before it is valid.
// When the receiver stalls, the output register holds its frame and the queue
// fills; cmd.ready drops only while the queue is full.
// Reset clears the drive state, counters and queue and loads the register
// defaults; no frame is pending after reset.
// ----------------------------------------------------------------------------
module motor_command_frame_generator_top
	import mcfg_pkg::*;
#(
	parameter int unsigned COUNTER_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mcfg_cmd_if.sink              cmd,
	mcfg_frame_if.source          frame,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic      push;
	logic      pop;
	logic      full;
	logic      empty;
	mcfg_job_t job_in;
	mcfg_job_t job_head;

	// Command front: state, counters and frame decisions.
	mcfg_front #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.full     (full),
		.push     (push),
		.job      (job_in)
	);

	// Job queue.
	mcfg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.job_in (job_in),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.job_out(job_head)
	);

	// Frame back: assembly and output register.
	mcfg_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.empty (empty),
		.job   (job_head),
		.pop   (pop),
		.frame (frame)
	);

`ifndef SYNTHESIS
	// Only the power frame closes a run.
	a_last_is_power: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid |-> (frame.last_frame == (frame.frame_id == ID_POWER)))
		else $error("last_frame does not match the power frame");

	// A taken speed frame is followed at once by the torque frame of its run.
	a_speed_then_torque: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready && frame.frame_id == ID_SPEED) |=>
		(frame.valid && frame.frame_id == ID_TORQUE))
		else $error("torque frame did not follow the speed frame");

	// A taken torque frame is followed at once by the power frame of its run.
	a_torque_then_power: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready && frame.frame_id == ID_TORQUE) |=>
		(frame.valid && frame.frame_id == ID_POWER))
		else $error("power frame did not follow the torque frame");

	// The queue never takes a job while it is full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue overflow");
`endif

endmodule

@@ design/mcfg_front.sv @@
// ----------------------------------------------------------------------------
// Motor command frame generator front
// Accepts commands, keeps the drive state and counters, and queues frame jobs.
// ----------------------------------------------------------------------------
module mcfg_front
	import mcfg_pkg::*;
#(
	parameter int unsigned COUNTER_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mcfg_cmd_if.sink              cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  full,
	output logic                  push,
	output mcfg_job_t             job
);

	localparam int CMP_W = (COUNTER_WIDTH > PERIOD_W) ? COUNTER_WIDTH : PERIOD_W;

	logic [PERIOD_W-1:0]      frame_period_q;
	logic [PERIOD_W-1:0]      ramp_gap_q;
	logic [SPEED_W-1:0]       speed_limit_q;
	logic [SPEED_W-1:0]       ramped_speed_q;
	logic [SPEED_W-1:0]       requested_speed_q;
	logic [SEL2_W-1:0]        drive_state_q;
	logic [SEL2_W-1:0]        gear_select_q;
	logic [TORQUE_W-1:0]      torque_bound_q;
	logic [HB_W-1:0]          heartbeat_q;
	logic [COUNTER_WIDTH-1:0] frame_elapsed_q;
	logic [COUNTER_WIDTH-1:0] ramp_elapsed_q;

	logic [COUNTER_WIDTH-1:0] frame_inc;
	logic [COUNTER_WIDTH-1:0] ramp_inc;
	logic                     accept;
	logic                     fire;
	logic                     step;

	// The front stalls only when the job queue has no free entry.
	assign cmd.ready = !full;
	assign accept    = cmd.valid && cmd.ready;

	// Saturating counter increments and the two threshold compares.
	always_comb begin
		frame_inc = (&frame_elapsed_q) ? frame_elapsed_q : frame_elapsed_q + 1'b1;
		ramp_inc  = (&ramp_elapsed_q) ? ramp_elapsed_q : ramp_elapsed_q + 1'b1;
		fire = CMP_W'(frame_inc) > CMP_W'(frame_period_q);
		step = (CMP_W'(ramp_inc) > CMP_W'(ramp_gap_q)) &&
			(ramped_speed_q != requested_speed_q);
	end

	// A firing tick hands the state from before the speed step to the back.
	assign push = accept && (op_t'(cmd.operation) == OP_TICK) && fire;
	assign job  = '{speed: ramped_speed_q, torque: torque_bound_q,
		drive_state: drive_state_q, gear: gear_select_q, heartbeat: heartbeat_q};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q <= FRAME_PERIOD_RST;
			ramp_gap_q     <= RAMP_GAP_RST;
			speed_limit_q  <= SPEED_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FRAME_PERIOD: frame_period_q <= cfg_data[PERIOD_W-1:0];
				CFG_RAMP_GAP:     ramp_gap_q     <= cfg_data[PERIOD_W-1:0];
				CFG_SPEED_LIMIT:  speed_limit_q  <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Drive state, counters and speed ramp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramped_speed_q    <= '0;
			requested_speed_q <= '0;
			drive_state_q     <= '0;
			gear_select_q     <= '0;
			torque_bound_q    <= '0;
			heartbeat_q       <= '0;
			frame_elapsed_q   <= '0;
			ramp_elapsed_q    <= '0;
		end else if (accept) begin
			unique case (op_t'(cmd.operation))
				OP_TICK: begin
					if (fire) begin
						frame_elapsed_q <= '0;
						heartbeat_q     <= heartbeat_q + HB_STEP;
					end else begin
						frame_elapsed_q <= frame_inc;
					end
					if (step) begin
						ramp_elapsed_q <= '0;
						if (ramped_speed_q < requested_speed_q) begin
							ramped_speed_q <= ramped_speed_q + 1'b1;
						end else begin
							ramped_speed_q <= ramped_speed_q - 1'b1;
						end
					end else begin
						ramp_elapsed_q <= ramp_inc;
					end
				end
				OP_SET_STATE: drive_state_q <= cmd.value[SEL2_W-1:0];
				OP_SET_GEAR:  gear_select_q <= cmd.value[SEL2_W-1:0];
				OP_SET_SPEED: begin
					if (cmd.value < VALUE_W'(speed_limit_q)) begin
						requested_speed_q <= cmd.value[SPEED_W-1:0];
					end
				end
				OP_SET_TORQ:  torque_bound_q <= cmd.value;
				OP_STOP: begin
					requested_speed_q <= '0;
					ramped_speed_q    <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ design/mcfg_queue.sv @@
// ----------------------------------------------------------------------------
// Motor command frame generator job queue
// Small FIFO of frame jobs between the front and the back.
// ----------------------------------------------------------------------------
module mcfg_queue
	import mcfg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  mcfg_job_t job_in,
	input  logic      pop,
	output logic      full,
	output logic      empty,
	output mcfg_job_t job_out
);

	mcfg_job_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign job_out = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/mcfg_back.sv @@
// ----------------------------------------------------------------------------
// Motor command frame generator back
// Turns each queued job into three frames and holds them in an output register.
// ----------------------------------------------------------------------------
module mcfg_back
	import mcfg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  mcfg_job_t job,
	output logic      pop,
	mcfg_frame_if.source frame
);

	frame_sel_t  sel_q;
	frame_sel_t  sel_d;
	logic        out_valid_q;
	mcfg_frame_t frame_q;
	logic        load;

	// A new frame enters the output register when it is free or being taken.
	assign load = !empty && (!out_valid_q || frame.ready);

	// Frame selector register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= FRM_SPEED;
		end else begin
			sel_q <= sel_d;
		end
	end

	// Next frame selection, and queue pop as the last frame of a run is loaded.
	always_comb begin
		sel_d = sel_q;
		pop   = 1'b0;
		if (load) begin
			unique case (sel_q)
				FRM_SPEED:  sel_d = FRM_TORQUE;
				FRM_TORQUE: sel_d = FRM_POWER;
				FRM_POWER: begin
					sel_d = FRM_SPEED;
					pop   = 1'b1;
				end
				default:    sel_d = FRM_SPEED;
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= build_frame(job, sel_q);
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_id   = frame_q.id;
	assign frame.byte_zero  = frame_q.bytes[0];
	assign frame.byte_one   = frame_q.bytes[1];
	assign frame.byte_two   = frame_q.bytes[2];
	assign frame.byte_three = frame_q.bytes[3];
	assign frame.byte_four  = frame_q.bytes[4];
	assign frame.byte_five  = frame_q.bytes[5];
	assign frame.byte_six   = frame_q.bytes[6];
	assign frame.byte_seven = frame_q.bytes[7];
	assign frame.last_frame = frame_q.last;

endmodule

@@ tb/tb_motor_command_frame_generator_top.sv @@
// ----------------------------------------------------------------------------
// Motor command frame generator testbench
// Drives operator commands and millisecond ticks into the block and tracks the
// drive state with a behavioral mirror. Every accepted frame is checked field
// by field against the oldest predicted frame. The run covers directed cases
// and random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_motor_command_frame_generator_top;
	import mcfg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 12;
	localparam int CNT_W          = 16;
	localparam int SETTLE_CYCLES  = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_CAP      = 100;
	localparam int VALUE_MAX      = 30000;
	localparam int RANDOM_ITEMS   = 30;

	// Operation codes outside the defined set; the block must ignore them.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
	} command_t;

	// Byte 7 of data is the checksum.
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [7:0][7:0] data;
		logic            last;
	} frame_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mcfg_cmd_if   cmd_bus ();
	mcfg_frame_if frame_bus ();

	motor_command_frame_generator_top #(
		.COUNTER_WIDTH(CNT_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.frame(frame_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Mirror of the configuration registers.
	logic [PERIOD_W-1:0] period_cfg;
	logic [PERIOD_W-1:0] gap_cfg;
	logic [SPEED_W-1:0]  limit_cfg;

	// Mirror of the drive state.
	logic [SPEED_W-1:0]  ramp_spd;
	logic [SPEED_W-1:0]  req_spd;
	logic [SEL2_W-1:0]   drv_state;
	logic [SEL2_W-1:0]   gear;
	logic [TORQUE_W-1:0] torque;
	logic [HB_W-1:0]     hb;
	logic [CNT_W-1:0]    frame_cnt;
	logic [CNT_W-1:0]    ramp_cnt;

	command_t pending_commands[$];
	frame_t   expected_frames[$];

	int sender_idle_pct;
	int receiver_stall_pct;
	int mismatches;
	int frames_seen;
	int quiet_cycles;

	// Clock generation.
	always #CLK_HALF clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP) begin
			$display("mismatch at frame %0d: %s", frames_seen, msg);
		end
		mismatches++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
		input int unsigned want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
		end
	endtask

	// Appends the checksum: two's complement of id low byte, data and bias.
	function automatic frame_t seal_frame(input logic [ID_W-1:0] id,
		input logic [6:0][7:0] d, input logic last);
		frame_t f;
		logic [7:0] sum;
		sum = id[7:0] + CHECKSUM_BIAS;
		for (int k = 0; k < 7; k++) begin
			sum = sum + d[k];
		end
		f.id = id;
		f.data[6:0] = d;
		f.data[7] = 8'h00 - sum;
		f.last = last;
		return f;
	endfunction

	// Advances the drive state by one command and queues the frames it causes.
	task automatic apply_command(input command_t c);
		logic [15:0] sp;
		logic [15:0] up;
		logic [15:0] lo;
		logic [6:0][7:0] d;
		case (c.op)
			OP_TICK: begin
				if (frame_cnt != '1) frame_cnt = frame_cnt + 1'b1;
				if (ramp_cnt != '1) ramp_cnt = ramp_cnt + 1'b1;
				if (frame_cnt > period_cfg) begin
					sp = SPEED_OFFSET + 16'(ramp_spd);
					up = TORQUE_OFFSET + 16'(torque);
					lo = TORQUE_OFFSET - 16'(torque);
					d = '0;
					d[0] = sp[15:8];
					d[1] = sp[7:0];
					d[5] = SPEED_FLAG_BYTE;
					d[6] = {drv_state, gear, hb};
					expected_frames.push_back(seal_frame(ID_SPEED, d, 1'b0));
					d = '0;
					d[0] = up[15:8];
					d[1] = up[7:0];
					d[2] = lo[15:8];
					d[3] = lo[7:0];
					d[4] = TORQUE_OFFSET[15:8];
					d[5] = TORQUE_OFFSET[7:0];
					d[6] = 8'(hb);
					expected_frames.push_back(seal_frame(ID_TORQUE, d, 1'b0));
					d = '0;
					d[0] = POWER_LIMIT_BYTE;
					d[2] = POWER_LIMIT_BYTE;
					d[5] = POWER_MODE_BYTE;
					d[6] = 8'(hb);
					expected_frames.push_back(seal_frame(ID_POWER, d, 1'b1));
					frame_cnt = '0;
					hb = hb + HB_STEP;
				end
				// The slew step comes after the frames, so they carry the old speed.
				if (ramp_cnt > gap_cfg && ramp_spd != req_spd) begin
					if (ramp_spd < req_spd) ramp_spd = ramp_spd + 1'b1;
					else ramp_spd = ramp_spd - 1'b1;
					ramp_cnt = '0;
				end
			end
			OP_SET_STATE: drv_state = c.value[SEL2_W-1:0];
			OP_SET_GEAR:  gear = c.value[SEL2_W-1:0];
			OP_SET_SPEED: begin
				if (c.value < limit_cfg) req_spd = c.value[SPEED_W-1:0];
			end
			OP_SET_TORQ:  torque = c.value;
			OP_STOP: begin
				req_spd = '0;
				ramp_spd = '0;
			end
			default: begin
				// Spare codes change nothing.
			end
		endcase
	endtask

	// Command driver: presents the oldest pending command and retires it on a
	// completed transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				apply_command(pending_commands.pop_front());
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (pending_commands.size() != 0 &&
					$urandom_range(99) >= sender_idle_pct) begin
					cmd_bus.valid <= 1'b1;
					cmd_bus.operation <= pending_commands[0].op;
					cmd_bus.value <= pending_commands[0].value;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Frame monitor: checks each frame transaction against the oldest prediction.
	always @(posedge clk) begin : frame_monitor
		frame_t got;
		frame_t want;
		if (arst_n) begin
			if (frame_bus.valid && frame_bus.ready) begin
				got.id = frame_bus.frame_id;
				got.data[0] = frame_bus.byte_zero;
				got.data[1] = frame_bus.byte_one;
				got.data[2] = frame_bus.byte_two;
				got.data[3] = frame_bus.byte_three;
				got.data[4] = frame_bus.byte_four;
				got.data[5] = frame_bus.byte_five;
				got.data[6] = frame_bus.byte_six;
				got.data[7] = frame_bus.byte_seven;
				got.last = frame_bus.last_frame;
				if (expected_frames.size() == 0) begin
					report_mismatch($sformatf("unexpected frame id 0x%0h", got.id));
				end else begin
					want = expected_frames.pop_front();
					check_field("frame_id", got.id, want.id);
					for (int k = 0; k < 8; k++) begin
						check_field($sformatf("byte %0d", k), got.data[k], want.data[k]);
					end
					check_field("last_frame", got.last, want.last);
				end
				frames_seen++;
			end
			frame_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Watchdog: ends the run when no transaction completes for too long.
	always @(posedge clk) begin
		if (!arst_n || (cmd_bus.valid && cmd_bus.ready) ||
			(frame_bus.valid && frame_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", quiet_cycles);
			$display("motor_command_frame_generator_top regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send(input logic [OP_W-1:0] op, input int value);
		command_t c;
		c.op = op;
		c.value = VALUE_W'(value);
		pending_commands.push_back(c);
	endtask

	task automatic send_ticks(input int count);
		for (int i = 0; i < count; i++) begin
			send(OP_TICK, $urandom_range(VALUE_MAX));
		end
	endtask

	// Waits until every command is taken and every predicted frame has arrived,
	// then lets the pipeline settle.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_commands.size() != 0 || cmd_bus.valid ||
			expected_frames.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FRAME_PERIOD: period_cfg = data;
			CFG_RAMP_GAP:     gap_cfg = data;
			CFG_SPEED_LIMIT:  limit_cfg = data[SPEED_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic configure(input int period, input int gap, input int limit);
		write_reg(CFG_FRAME_PERIOD, CFG_DATA_W'(period));
		write_reg(CFG_RAMP_GAP, CFG_DATA_W'(gap));
		write_reg(CFG_SPEED_LIMIT, CFG_DATA_W'(limit));
	endtask

	// Random command mix: mostly ticks so frame runs are frequent, with speed
	// requests clustered around the limit.
	function automatic command_t random_command();
		command_t c;
		int pick;
		int v;
		pick = $urandom_range(99);
		c.value = VALUE_W'($urandom_range(VALUE_MAX));
		if (pick < 55) begin
			c.op = OP_TICK;
		end else if (pick < 70) begin
			c.op = OP_SET_SPEED;
			case ($urandom_range(4))
				0: v = int'(limit_cfg) - 1;
				1: v = int'(limit_cfg);
				2: v = int'(limit_cfg) + 1;
				3: v = $urandom_range(4095);
				default: v = $urandom_range(VALUE_MAX);
			endcase
			c.value = VALUE_W'(v);
		end else if (pick < 78) begin
			c.op = OP_SET_TORQ;
			if ($urandom_range(3) == 0) c.value = $urandom_range(1) ? VALUE_W'(VALUE_MAX) : '0;
		end else if (pick < 85) begin
			c.op = OP_SET_STATE;
		end else if (pick < 92) begin
			c.op = OP_SET_GEAR;
		end else if (pick < 97) begin
			c.op = OP_STOP;
		end else begin
			c.op = $urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI;
		end
		return c;
	endfunction

	task automatic run_random(input int idle, input int stall, input int count,
		input bit pause_midway);
		sender_idle_pct = idle;
		receiver_stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2) wait_drained();
			pending_commands.push_back(random_command());
		end
		wait_drained();
	endtask

	// Stimulus sequence.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FRAME_PERIOD;
		cfg_data = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.operation = OP_TICK;
		cmd_bus.value = '0;
		frame_bus.ready = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		mismatches = 0;
		frames_seen = 0;
		quiet_cycles = 0;
		period_cfg = FRAME_PERIOD_RST;
		gap_cfg = RAMP_GAP_RST;
		limit_cfg = SPEED_LIMIT_RST;
		ramp_spd = '0;
		req_spd = '0;
		drv_state = '0;
		gear = '0;
		torque = '0;
		hb = '0;
		frame_cnt = '0;
		ramp_cnt = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults: requests at the limit are dropped, one frame run
		// follows once the tick count passes the reset period.
		send(OP_SET_SPEED, int'(SPEED_LIMIT_RST));
		send(OP_SET_SPEED, int'(SPEED_LIMIT_RST) - 1);
		send_ticks(int'(FRAME_PERIOD_RST) + 2);
		wait_drained();

		// Directed cases: field extremes, every operation, spare codes, stop.
		configure(2, 0, 4095);
		send(OP_SET_STATE, 29999);
		send(OP_SET_GEAR, 3);
		send(OP_SET_TORQ, VALUE_MAX);
		send(OP_SET_SPEED, 4094);
		send(OP_SET_SPEED, 4095);
		send_ticks(3);
		send(OP_SET_TORQ, 0);
		send(OP_SET_STATE, 2);
		send(OP_SET_GEAR, 1);
		send(OP_SPARE_LO, VALUE_MAX);
		send(OP_SPARE_HI, 12345);
		send_ticks(3);
		send(OP_STOP, 0);
		send_ticks(3);
		send(OP_SET_TORQ, 1);
		send(OP_SET_SPEED, 0);
		send_ticks(3);
		wait_drained();

		// Speed limit of one: only a request of zero is taken.
		configure(1, 0, 1);
		send(OP_SET_SPEED, 1);
		send(OP_SET_SPEED, 0);
		send_ticks(2);
		wait_drained();

		// Random traffic under each idle and stall mix.
		configure($urandom_range(1, 5), $urandom_range(0, 3), $urandom_range(1, 4095));
		run_random(0, 0, RANDOM_ITEMS, 1'b0);
		configure($urandom_range(1, 5), $urandom_range(0, 3), 4095);
		run_random(45, 0, RANDOM_ITEMS, 1'b1);
		configure(1, 0, $urandom_range(1, 4095));
		run_random(0, 45, RANDOM_ITEMS, 1'b0);
		configure($urandom_range(1, 3), $urandom_range(0, 6), $urandom_range(1, 4095));
		run_random(36, 36, RANDOM_ITEMS, 1'b0);

		if (mismatches == 0) begin
			$display("motor_command_frame_generator_top regression: pass");
		end else begin
			$display("motor_command_frame_generator_top regression: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/mcfg_pkg.sv
design/mcfg_ifs.sv
design/mcfg_front.sv
design/mcfg_queue.sv
design/mcfg_back.sv
design/motor_command_frame_generator_top.sv
tb/tb_motor_command_frame_generator_top.sv
